// ===== rtl/core/mbbo_pkg.sv =====
// Package for the 1-bit mask OR blitter.
// Holds the address width, the command record and the register index codes.
// No dependencies.
package mbbo_pkg;

  localparam int unsigned ADDR_W = 21;
  localparam int unsigned CFG_W  = 13;

  // One OR-write command to the destination mask.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        bits;
    logic              last;
  } cmd_t;

  // Register index codes of the configuration port.
  typedef enum logic [2:0] {
    CFG_DEST_WIDTH  = 3'd0,
    CFG_DEST_HEIGHT = 3'd1,
    CFG_PLACE_X     = 3'd2,
    CFG_PLACE_Y     = 3'd3,
    CFG_SRC_WIDTH   = 3'd4,
    CFG_SRC_HEIGHT  = 3'd5,
    CFG_DEST_STRIDE = 3'd6,
    CFG_SRC_STRIDE  = 3'd7
  } cfg_idx_e;

endpackage

// ===== rtl/core/mask_bit_blit_or.sv =====
// Top level of the 1-bit mask OR blitter: input stage, command builder and a
// two-entry output stage. Depends on mbbo_pkg.
//
//   Channel   Direction  Handshake                 Payload
//   --------  ---------  ------------------------  ------------------------------------
//   input     in         in_valid_i / in_stall_o   mask_byte_i, frame_start_i
//   output    out        out_valid_o / out_stall_i dest_addr_o, or_bits_o, last_o
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A byte that yields two commands (an unaligned placement) keeps the next
// byte with commands waiting in the input stage until its spilled command has
// moved on, since the single result register shows one command per cycle while
// the output is not stalled. An accepted byte passes the input stage, then the output stage.
// Reset clears the row and column counters and the row base, and loads the
// registers with a placement of zero and all sizes and strides equal to one.
// A stall on the output backs up through the pending slot into the input
// stage; the input side stalls only when the input stage cannot move on.
module mask_bit_blit_or
  import mbbo_pkg::*;
#(
  parameter int unsigned MAX_SIDE   = 4096,
  parameter int unsigned MAX_STRIDE = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input byte stream.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        mask_byte_i,
  input  logic              frame_start_i,
  // OR-write command stream.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ADDR_W-1:0] dest_addr_o,
  output logic [7:0]        or_bits_o,
  output logic              last_o,
  // Register write port.
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  // Row counter holds MAX_SIDE, column counter holds MAX_STRIDE.
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned COL_W  = $clog2(MAX_STRIDE + 1);
  localparam int unsigned STRW   = (COL_W > 10) ? COL_W : 10;
  localparam int unsigned EXTW   = (SIDE_W > 13) ? SIDE_W : 13;
  localparam int unsigned CMPW   = (EXTW > COL_W) ? EXTW : COL_W;
  localparam int unsigned PRODW  = 12 + STRW;

  // Configuration registers.
  logic [12:0] dest_width_q, dest_height_q, src_width_q, src_height_q;
  logic [11:0] place_x_q, place_y_q;
  logic [9:0]  dest_stride_q, src_stride_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_width_q  <= 13'd1;
      dest_height_q <= 13'd1;
      place_x_q     <= 12'd0;
      place_y_q     <= 12'd0;
      src_width_q   <= 13'd1;
      src_height_q  <= 13'd1;
      dest_stride_q <= 10'd1;
      src_stride_q  <= 10'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEST_WIDTH:  dest_width_q  <= cfg_data_i[12:0];
        CFG_DEST_HEIGHT: dest_height_q <= cfg_data_i[12:0];
        CFG_PLACE_X:     place_x_q     <= cfg_data_i[11:0];
        CFG_PLACE_Y:     place_y_q     <= cfg_data_i[11:0];
        CFG_SRC_WIDTH:   src_width_q   <= cfg_data_i[12:0];
        CFG_SRC_HEIGHT:  src_height_q  <= cfg_data_i[12:0];
        CFG_DEST_STRIDE: dest_stride_q <= cfg_data_i[9:0];
        CFG_SRC_STRIDE:  src_stride_q  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Effective strides. A zero or oversized overlay stride means the maximum;
  // an oversized destination stride is clamped.
  logic [STRW-1:0] eff_dest, eff_src;
  always_comb begin
    eff_dest = (STRW'(dest_stride_q) > STRW'(MAX_STRIDE)) ? STRW'(MAX_STRIDE)
                                                          : STRW'(dest_stride_q);
    if (src_stride_q == 10'd0 || STRW'(src_stride_q) > STRW'(MAX_STRIDE)) begin
      eff_src = STRW'(MAX_STRIDE);
    end else begin
      eff_src = STRW'(src_stride_q);
    end
  end

  // Raster position counters.
  logic [SIDE_W-1:0] row_q;
  logic [COL_W-1:0]  col_q;
  logic [ADDR_W-1:0] base_q;

  // Input stage.
  logic              s1_valid_q;
  logic [7:0]        s1_pix_q;
  logic [SIDE_W-1:0] s1_row_q;
  logic [COL_W-1:0]  s1_col_q;
  logic [ADDR_W-1:0] s1_base_q;

  // Output stage: the shown command and the spilled command behind it.
  logic out_valid_q, pend_valid_q;
  cmd_t out_q, pend_q;

  logic in_accept, s1_adv, slot_free, load_cmds;

  // Position of the arriving byte; a frame start restarts the overlay and
  // places the row base at the first destination row.
  logic [PRODW-1:0]  base_prod;
  logic [SIDE_W-1:0] row_eff;
  logic [COL_W-1:0]  col_eff, col_inc;
  logic [ADDR_W-1:0] base_eff;

  always_comb begin
    base_prod = PRODW'(place_y_q) * PRODW'(eff_dest);
    row_eff   = frame_start_i ? '0 : row_q;
    col_eff   = frame_start_i ? '0 : col_q;
    base_eff  = frame_start_i ? ADDR_W'(base_prod) : base_q;
    col_inc   = col_eff + COL_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      base_q <= '0;
    end else if (in_accept) begin
      if (STRW'(col_inc) >= eff_src) begin
        col_q <= '0;
        // The row counter stops at MAX_SIDE, which lies past any clipped height.
        if (row_eff < SIDE_W'(MAX_SIDE)) begin
          row_q  <= row_eff + SIDE_W'(1);
          base_q <= base_eff + ADDR_W'(eff_dest);
        end else begin
          row_q  <= row_eff;
          base_q <= base_eff;
        end
      end else begin
        col_q  <= col_inc;
        row_q  <= row_eff;
        base_q <= base_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q  <= mask_byte_i;
      s1_row_q  <= row_eff;
      s1_col_q  <= col_eff;
      s1_base_q <= base_eff;
    end
  end

  // Clipped extents: a non-positive room gives zero, then cap at MAX_SIDE.
  logic [12:0]     room_w, room_h, ext_w, ext_h;
  logic [EXTW-1:0] w, h, full;
  logic [2:0]      tail, shift;
  logic [3:0]      reach;
  logic            row_ok, col_lt_full, col_eq_full;
  logic [ADDR_W-1:0] addr;
  logic [7:0]      masked;
  cmd_t            cmd0, cmd1;
  logic [1:0]      ncmd;

  always_comb begin
    room_w = (dest_width_q > {1'b0, place_x_q}) ? dest_width_q - {1'b0, place_x_q} : 13'd0;
    room_h = (dest_height_q > {1'b0, place_y_q}) ? dest_height_q - {1'b0, place_y_q} : 13'd0;
    ext_w  = (src_width_q < room_w) ? src_width_q : room_w;
    ext_h  = (src_height_q < room_h) ? src_height_q : room_h;
    w = (EXTW'(ext_w) > EXTW'(MAX_SIDE)) ? EXTW'(MAX_SIDE) : EXTW'(ext_w);
    h = (EXTW'(ext_h) > EXTW'(MAX_SIDE)) ? EXTW'(MAX_SIDE) : EXTW'(ext_h);
    full  = w >> 3;
    tail  = w[2:0];
    shift = place_x_q[2:0];
    reach = {1'b0, tail} + {1'b0, shift};

    row_ok      = EXTW'(s1_row_q) < h;
    col_lt_full = CMPW'(s1_col_q) < CMPW'(full);
    col_eq_full = CMPW'(s1_col_q) == CMPW'(full);

    addr   = s1_base_q + ADDR_W'(place_x_q[11:3]) + ADDR_W'(s1_col_q);
    // Keep only the leftmost tail pixels of the last partial byte.
    masked = s1_pix_q & ~(8'hFF >> tail);

    cmd0 = '{addr: addr, bits: s1_pix_q, last: 1'b1};
    cmd1 = '{addr: addr + ADDR_W'(1), bits: 8'd0, last: 1'b1};
    ncmd = 2'd0;

    if (row_ok && s1_pix_q != 8'd0) begin
      if (col_lt_full) begin
        if (shift == 3'd0) begin
          ncmd = 2'd1;
        end else begin
          // The spilled half is sent even when its bits are all zero.
          cmd0.bits = s1_pix_q >> shift;
          cmd0.last = 1'b0;
          cmd1.bits = s1_pix_q << (4'd8 - {1'b0, shift});
          ncmd      = 2'd2;
        end
      end else if (col_eq_full && tail != 3'd0) begin
        cmd0.bits = masked >> shift;
        if (reach > 4'd8) begin
          cmd0.last = 1'b0;
          cmd1.bits = masked << (4'd8 - {1'b0, shift});
          ncmd      = 2'd2;
        end else begin
          ncmd = 2'd1;
        end
      end
    end
  end

  // The input stage moves on when its byte yields nothing, or when both
  // output slots will be free after this cycle.
  assign slot_free  = !pend_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_adv     = s1_valid_q && ((ncmd == 2'd0) || slot_free);
  assign load_cmds  = s1_adv && (ncmd != 2'd0);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (load_cmds) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= (ncmd == 2'd2);
      end else if (pend_valid_q) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (load_cmds) begin
        out_q  <= cmd0;
        pend_q <= cmd1;
      end else if (pend_valid_q) begin
        out_q  <= pend_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign dest_addr_o = out_q.addr;
  assign or_bits_o   = out_q.bits;
  assign last_o      = out_q.last;

  // A spilled command only waits behind a shown command of the same byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (out_valid_q && !out_q.last && pend_q.last))
    else $error("pending command without its first half");

  // A shown first half always has its spilled half queued behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |-> pend_valid_q)
    else $error("first half shown without spilled half");

  // Taking the first half brings the spilled half to the output next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && pend_valid_q) |=>
      (out_valid_q && out_q.last && out_q.addr == $past(pend_q.addr)))
    else $error("spilled command lost or altered");

  // The input side only stalls while a byte sits in the input stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input stage");

endmodule
